// ----- rtl/wsdf_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Phase codes, result kinds, parser state and result records.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  localparam int unsigned      MAX_W          = 31;
  localparam logic [MAX_W-1:0] MAX_BYTES_RST  = 31'd65518;
  localparam logic [3:0]       OP_CLOSE       = 4'h8;
  localparam logic [6:0]       LEN7_EXT16     = 7'd126;
  localparam logic [6:0]       LEN7_EXT64     = 7'd127;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_CLOSE   = 2'd2;
  localparam logic [1:0] KIND_ILLEGAL = 2'd3;

  typedef enum logic [6:0] {
    PH_HDR0  = 7'b0000001,
    PH_HDR1  = 7'b0000010,
    PH_EXT16 = 7'b0000100,
    PH_EXT64 = 7'b0001000,
    PH_KEY   = 7'b0010000,
    PH_LEN   = 7'b0100000,
    PH_DATA  = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic             cur_fin;
    logic [3:0]       cur_opcode;
    logic             masked;
    logic [31:0]      mask_key;
    logic [2:0]       byte_count;
    logic [1:0]       key_position;
    logic [31:0]      length_accum;
    logic [MAX_W-1:0] remaining;
    logic             stopped;
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [7:0]       key_byte;
    logic [MAX_W-1:0] packet_length;
    logic             is_last;
    logic             fin_bit;
    logic [3:0]       frame_opcode;
  } result_t;

endpackage

// ----- rtl/websocket_frame_deframer_core.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer core
// Receive-side frame header parser with inner length check; data bytes leave with their mask key byte.
// ----------------------------------------------------------------------------
// One received byte is taken per item and the block sustains one item per
// clock while out_ready does not stall it. Each byte passes through an input
// register, one parser step and a result register. Key bytes give no result,
// header and extension bytes give one only for a close frame, and only the
// last inner length byte gives one. A close frame or an illegal inner length
// gives one result and then the block drops every further byte until reset.
module websocket_frame_deframer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_data_byte,
  output logic [7:0]                 out_key_byte,
  output logic [wsdf_pkg::MAX_W-1:0] out_packet_length,
  output logic                       out_is_last,
  output logic                       out_fin_bit,
  output logic [3:0]                 out_frame_opcode,
  input  logic                       cfg_wr_en,
  input  logic [wsdf_pkg::MAX_W-1:0] cfg_wr_data
);

  logic                       in_valid_r;
  logic [7:0]                 in_byte_r;
  logic                       out_valid_r;
  wsdf_pkg::result_t          out_res_r;
  wsdf_pkg::state_t           st_r;
  wsdf_pkg::state_t           st_nxt;
  wsdf_pkg::result_t          res;
  logic                       res_valid;
  logic [wsdf_pkg::MAX_W-1:0] max_bytes_r;
  logic                       advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  wsdf_parser u_parser (
    .st        (st_r),
    .rx_byte   (in_byte_r),
    .max_bytes (max_bytes_r),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= wsdf_pkg::MAX_BYTES_RST;
    end else if (cfg_wr_en) begin
      max_bytes_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: wsdf_pkg::PH_HDR0, cur_fin: 1'b0, cur_opcode: 4'h0, masked: 1'b0,
                mask_key: 32'h0, byte_count: 3'd0, key_position: 2'd0,
                length_accum: 32'h0, remaining: '0, stopped: 1'b0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_data_byte     = out_res_r.data_byte;
  assign out_key_byte      = out_res_r.key_byte;
  assign out_packet_length = out_res_r.packet_length;
  assign out_is_last       = out_res_r.is_last;
  assign out_fin_bit       = out_res_r.fin_bit;
  assign out_frame_opcode  = out_res_r.frame_opcode;

endmodule

// ----- rtl/wsdf_parser.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer parser step
// Next parser state and optional result for one received byte.
// ----------------------------------------------------------------------------
module wsdf_parser (
  input  wsdf_pkg::state_t              st,
  input  logic [7:0]                    rx_byte,
  input  logic [wsdf_pkg::MAX_W-1:0]    max_bytes,
  output wsdf_pkg::state_t              st_nxt,
  output logic                          res_valid,
  output wsdf_pkg::result_t             res
);

  logic       hdr_done;
  logic [7:0] key_cur;
  logic [7:0] len_byte;
  logic [4:0] bc_sel;
  logic       len_bad;

  assign key_cur  = st.masked ? st.mask_key[{st.key_position, 3'b000} +: 8] : 8'h00;
  assign len_byte = rx_byte ^ key_cur;
  assign bc_sel   = {st.byte_count[1:0], 3'b000};

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res       = '0;
    hdr_done  = 1'b0;
    len_bad   = 1'b0;
    if (!st.stopped) begin
      case (st.phase)
        wsdf_pkg::PH_HDR0: begin
          st_nxt.cur_fin    = rx_byte[7];
          st_nxt.cur_opcode = rx_byte[3:0];
          st_nxt.masked     = 1'b0;
          st_nxt.mask_key   = 32'h0;
          st_nxt.phase      = wsdf_pkg::PH_HDR1;
        end
        wsdf_pkg::PH_HDR1: begin
          st_nxt.masked     = rx_byte[7];
          st_nxt.byte_count = 3'd0;
          if (rx_byte[6:0] == wsdf_pkg::LEN7_EXT16) begin
            st_nxt.phase = wsdf_pkg::PH_EXT16;
          end else if (rx_byte[6:0] == wsdf_pkg::LEN7_EXT64) begin
            st_nxt.phase = wsdf_pkg::PH_EXT64;
          end else begin
            hdr_done = 1'b1;
          end
        end
        wsdf_pkg::PH_EXT16: begin
          if (st.byte_count >= 3'd1) begin
            hdr_done = 1'b1;
          end else begin
            st_nxt.byte_count = st.byte_count + 3'd1;
          end
        end
        wsdf_pkg::PH_EXT64: begin
          if (st.byte_count >= 3'd7) begin
            hdr_done = 1'b1;
          end else begin
            st_nxt.byte_count = st.byte_count + 3'd1;
          end
        end
        wsdf_pkg::PH_KEY: begin
          st_nxt.mask_key[bc_sel +: 8] = st.mask_key[bc_sel +: 8] | rx_byte;
          if (st.byte_count >= 3'd3) begin
            st_nxt.byte_count = 3'd0;
            st_nxt.phase      = wsdf_pkg::PH_LEN;
          end else begin
            st_nxt.byte_count = st.byte_count + 3'd1;
          end
        end
        wsdf_pkg::PH_LEN: begin
          st_nxt.length_accum[bc_sel +: 8] = st.length_accum[bc_sel +: 8] | len_byte;
          st_nxt.key_position = st.key_position + 2'd1;
          if (st.byte_count < 3'd3) begin
            st_nxt.byte_count = st.byte_count + 3'd1;
          end else begin
            st_nxt.byte_count = 3'd0;
            // negative, empty or oversized inner length stops the block
            len_bad = st_nxt.length_accum[31] || (st_nxt.length_accum == 32'h0) ||
                      (st_nxt.length_accum[wsdf_pkg::MAX_W-1:0] > max_bytes);
            res_valid = 1'b1;
            if (len_bad) begin
              st_nxt.stopped = 1'b1;
              res.kind       = wsdf_pkg::KIND_ILLEGAL;
            end else begin
              st_nxt.remaining  = st_nxt.length_accum[wsdf_pkg::MAX_W-1:0];
              st_nxt.phase      = wsdf_pkg::PH_DATA;
              res.kind          = wsdf_pkg::KIND_START;
              res.packet_length = st_nxt.length_accum[wsdf_pkg::MAX_W-1:0];
            end
          end
        end
        wsdf_pkg::PH_DATA: begin
          st_nxt.key_position = st.key_position + 2'd1;
          st_nxt.remaining    = st.remaining - 31'd1;
          res_valid           = 1'b1;
          res.kind            = wsdf_pkg::KIND_DATA;
          res.data_byte       = rx_byte;
          res.key_byte        = key_cur;
          if (st_nxt.remaining == '0) begin
            res.is_last  = 1'b1;
            st_nxt.phase = wsdf_pkg::PH_HDR0;
          end
        end
        default: begin
          st_nxt.phase = wsdf_pkg::PH_HDR0;
        end
      endcase

      if (hdr_done) begin
        st_nxt.byte_count   = 3'd0;
        st_nxt.key_position = 2'd0;
        st_nxt.length_accum = 32'h0;
        if (st_nxt.cur_opcode == wsdf_pkg::OP_CLOSE) begin
          st_nxt.stopped = 1'b1;
          res_valid      = 1'b1;
          res.kind       = wsdf_pkg::KIND_CLOSE;
        end else begin
          st_nxt.phase = st_nxt.masked ? wsdf_pkg::PH_KEY : wsdf_pkg::PH_LEN;
        end
      end
    end
    res.fin_bit      = st_nxt.cur_fin;
    res.frame_opcode = st_nxt.cur_opcode;
  end

endmodule

// ----- rtl/wsdf_checker.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer port checker
// Port-level properties of the deframer core, bound to the deframer core module.
// ----------------------------------------------------------------------------
module wsdf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_kind,
  input logic [7:0]                 out_data_byte,
  input logic [7:0]                 out_key_byte,
  input logic [wsdf_pkg::MAX_W-1:0] out_packet_length,
  input logic                       out_is_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_data_byte) && $stable(out_key_byte) && $stable(out_packet_length))
    else $error("result changed while stalled");

  // nothing follows a close or an illegal size
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready &&
    (out_kind == wsdf_pkg::KIND_CLOSE || out_kind == wsdf_pkg::KIND_ILLEGAL)
    |=> !out_valid)
    else $error("result after stop");

  a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |-> out_kind == wsdf_pkg::KIND_DATA)
    else $error("last flag on a non-data item");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != wsdf_pkg::KIND_START |-> out_packet_length == '0)
    else $error("packet length outside packet start");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != wsdf_pkg::KIND_DATA |->
    out_data_byte == 8'h00 && out_key_byte == 8'h00)
    else $error("data or key byte outside data item");

endmodule

bind websocket_frame_deframer_core wsdf_checker u_wsdf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_data_byte     (out_data_byte),
  .out_key_byte      (out_key_byte),
  .out_packet_length (out_packet_length),
  .out_is_last       (out_is_last)
);
